// File: sv/assert_macros.svh
// Assertion helpers, clocked on a rising edge and disabled while reset is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("implication check failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// File: sv/ipm_msrt_pkg.sv
package ipm_msrt_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int STEP_FRAC   = 30;
  localparam int STEP_W      = STEP_FRAC + 1;
  localparam int PROD_W      = STEP_W + VALUE_WIDTH;
  localparam int PAIRS       = 4;
  localparam int PAIR_IDX_W  = $clog2(PAIRS);
  localparam int DIV_CNT_W   = $clog2(STEP_FRAC);

  localparam logic [STEP_W-1:0]     STEP_ONE      = STEP_W'(1) << STEP_FRAC;
  localparam logic [PAIR_IDX_W-1:0] LAST_PAIR_IDX = PAIR_IDX_W'(PAIRS - 1);
  localparam logic [DIV_CNT_W-1:0]  DIV_LAST      = DIV_CNT_W'(STEP_FRAC - 1);

  typedef struct packed {
    logic load;
    logic cmp;
    logic mul;
    logic div_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic lower;
    logic div_done;
    logic last;
  } status_t;

endpackage

// File: sv/ipm_max_step_ratio_test.sv
// Sequence: an item is loaded, then each of its four pairs is compared in turn; a pair that
// lowers the step runs a restoring divide and, for the first three pairs, one multiply. On a
// last_pair item the result then goes to out_valid_o; a full output register holds it back.
// One item is handled at a time by the single compare multiplier and divider, so in_ready_o
// is low until it is done; a result waiting in the output register does not block the next.
// Reset (asynchronous, active low): step back to 1.0, flags cleared, no result pending.
`include "assert_macros.svh"

module ipm_max_step_ratio_test (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        in_valid_i,
  output logic                                        in_ready_o,
  input  logic signed [ipm_msrt_pkg::VALUE_WIDTH-1:0] dual_lower_i,
  input  logic signed [ipm_msrt_pkg::VALUE_WIDTH-1:0] dual_lower_step_i,
  input  logic signed [ipm_msrt_pkg::VALUE_WIDTH-1:0] dual_upper_i,
  input  logic signed [ipm_msrt_pkg::VALUE_WIDTH-1:0] dual_upper_step_i,
  input  logic signed [ipm_msrt_pkg::VALUE_WIDTH-1:0] slack_lower_i,
  input  logic signed [ipm_msrt_pkg::VALUE_WIDTH-1:0] slack_lower_step_i,
  input  logic signed [ipm_msrt_pkg::VALUE_WIDTH-1:0] slack_upper_i,
  input  logic signed [ipm_msrt_pkg::VALUE_WIDTH-1:0] slack_upper_step_i,
  input  logic                                        last_pair_i,
  output logic                                        out_valid_o,
  input  logic                                        out_ready_i,
  output logic [ipm_msrt_pkg::STEP_W-1:0]             step_length_o,
  output logic                                        step_clipped_o,
  output logic                                        bad_point_o
);
  import ipm_msrt_pkg::*;

  cmd_t    cmd;
  status_t status;

  ipm_msrt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  ipm_msrt_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .dual_lower_i       (dual_lower_i),
    .dual_lower_step_i  (dual_lower_step_i),
    .dual_upper_i       (dual_upper_i),
    .dual_upper_step_i  (dual_upper_step_i),
    .slack_lower_i      (slack_lower_i),
    .slack_lower_step_i (slack_lower_step_i),
    .slack_upper_i      (slack_upper_i),
    .slack_upper_step_i (slack_upper_step_i),
    .last_pair_i        (last_pair_i),
    .step_length_o      (step_length_o),
    .step_clipped_o     (step_clipped_o),
    .bad_point_o        (bad_point_o)
  );

  `ASSERT_IMPLY(a_step_max, clk_i, rst_ni, out_valid_o, step_length_o <= STEP_ONE)
  `ASSERT_IMPLY(a_bad_zero, clk_i, rst_ni, out_valid_o && bad_point_o, step_length_o == '0)
  `ASSERT_IMPLY(a_unclipped_one, clk_i, rst_ni, out_valid_o && !step_clipped_o,
                step_length_o == STEP_ONE)
  `ASSERT_NEXT(a_load_busy, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)

endmodule

// File: sv/ipm_msrt_dp.sv
module ipm_msrt_dp (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  ipm_msrt_pkg::cmd_t                               cmd_i,
  output ipm_msrt_pkg::status_t                            status_o,
  input  logic signed [ipm_msrt_pkg::VALUE_WIDTH-1:0]      dual_lower_i,
  input  logic signed [ipm_msrt_pkg::VALUE_WIDTH-1:0]      dual_lower_step_i,
  input  logic signed [ipm_msrt_pkg::VALUE_WIDTH-1:0]      dual_upper_i,
  input  logic signed [ipm_msrt_pkg::VALUE_WIDTH-1:0]      dual_upper_step_i,
  input  logic signed [ipm_msrt_pkg::VALUE_WIDTH-1:0]      slack_lower_i,
  input  logic signed [ipm_msrt_pkg::VALUE_WIDTH-1:0]      slack_lower_step_i,
  input  logic signed [ipm_msrt_pkg::VALUE_WIDTH-1:0]      slack_upper_i,
  input  logic signed [ipm_msrt_pkg::VALUE_WIDTH-1:0]      slack_upper_step_i,
  input  logic                                             last_pair_i,
  output logic [ipm_msrt_pkg::STEP_W-1:0]                  step_length_o,
  output logic                                             step_clipped_o,
  output logic                                             bad_point_o
);
  import ipm_msrt_pkg::*;

  localparam int W = VALUE_WIDTH;

  function automatic logic [W-1:0] dir_mag(input logic [W-1:0] d);
    return ~d + W'(1);
  endfunction

  logic signed [W-1:0] val_q [PAIRS];
  logic signed [W-1:0] dir_q [PAIRS];
  logic                last_q;

  logic [STEP_W-1:0] step_d, step_q;
  logic              clip_d, clip_q;
  logic              bad_d, bad_q;

  logic [PROD_W-1:0] prod_d, prod_q;
  logic [W-1:0]      mul_dir;

  logic [W:0]           rem_q, rem_sh, rem_d;
  logic [W-1:0]         den_q;
  logic [STEP_FRAC-1:0] quo_q, quo_d;
  logic [DIV_CNT_W-1:0] dcnt_q;
  logic                 ge;

  logic              blocking, v_pos, bad_now, lower;
  logic [PROD_W-1:0] v_sh;

  // pair under test always sits in slot 0
  assign blocking = dir_q[0][W-1];
  assign v_pos    = !val_q[0][W-1] && (val_q[0] != '0);
  assign bad_now  = blocking && !v_pos;
  assign v_sh     = PROD_W'({val_q[0], {STEP_FRAC{1'b0}}});
  assign lower    = blocking && v_pos && (v_sh < prod_q);

  always_comb begin
    if (cmd_i.load) begin
      mul_dir = dual_lower_step_i;
    end else if (cmd_i.cmp) begin
      mul_dir = dir_q[1];
    end else begin
      mul_dir = dir_q[0];
    end
    prod_d = step_q * dir_mag(mul_dir);
    if (cmd_i.cmp && bad_now) begin
      prod_d = '0;
    end
  end

  assign rem_sh = {rem_q[W-1:0], 1'b0};
  assign ge     = rem_sh >= {1'b0, den_q};
  assign rem_d  = ge ? rem_sh - {1'b0, den_q} : rem_sh;
  assign quo_d  = {quo_q[STEP_FRAC-2:0], ge};

  assign status_o.lower    = cmd_i.cmp && lower;
  assign status_o.div_done = dcnt_q == DIV_LAST;
  assign status_o.last     = last_q;

  always_comb begin
    step_d = step_q;
    clip_d = clip_q;
    bad_d  = bad_q;
    if (cmd_i.cmp) begin
      if (bad_now) begin
        bad_d = 1'b1;
        if (step_q != '0) begin
          step_d = '0;
          clip_d = 1'b1;
        end
      end else if (lower) begin
        clip_d = 1'b1;
      end
    end
    if (cmd_i.div_step && status_o.div_done) begin
      step_d = STEP_W'(quo_d);
    end
    if (cmd_i.emit) begin
      step_d = STEP_ONE;
      clip_d = 1'b0;
      bad_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_ONE;
      clip_q <= 1'b0;
      bad_q  <= 1'b0;
    end else begin
      step_q <= step_d;
      clip_q <= clip_d;
      bad_q  <= bad_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      val_q[0] <= dual_lower_i;
      dir_q[0] <= dual_lower_step_i;
      val_q[1] <= dual_upper_i;
      dir_q[1] <= dual_upper_step_i;
      val_q[2] <= slack_lower_i;
      dir_q[2] <= slack_lower_step_i;
      val_q[3] <= slack_upper_i;
      dir_q[3] <= slack_upper_step_i;
      last_q   <= last_pair_i;
    end else if (cmd_i.cmp) begin
      for (int i = 0; i < PAIRS - 1; i++) begin
        val_q[i] <= val_q[i+1];
        dir_q[i] <= dir_q[i+1];
      end
    end
    if (cmd_i.load || cmd_i.cmp || cmd_i.mul) begin
      prod_q <= prod_d;
    end
    if (cmd_i.cmp && lower) begin
      rem_q  <= {1'b0, val_q[0]};
      den_q  <= dir_mag(dir_q[0]);
      quo_q  <= '0;
      dcnt_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q  <= rem_d;
      quo_q  <= quo_d;
      dcnt_q <= dcnt_q + DIV_CNT_W'(1);
    end
    if (cmd_i.emit) begin
      step_length_o  <= step_q;
      step_clipped_o <= clip_q;
      bad_point_o    <= bad_q;
    end
  end

endmodule

// File: sv/ipm_msrt_ctrl.sv
module ipm_msrt_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  ipm_msrt_pkg::status_t status_i,
  output ipm_msrt_pkg::cmd_t    cmd_o
);
  import ipm_msrt_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CMP  = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0]            state_d, state_q;
  logic [PAIR_IDX_W-1:0] cnt_d, cnt_q;
  logic                  ovalid_d, ovalid_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = ST_CMP;
        end
      end
      ST_CMP: begin
        cmd_o.cmp = 1'b1;
        cnt_d     = cnt_q + PAIR_IDX_W'(1);
        if (status_i.lower) begin
          state_d = ST_DIV;
        end else if (cnt_q == LAST_PAIR_IDX) begin
          state_d = status_i.last ? ST_FIN : ST_IDLE;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_done) begin
          if (cnt_q == '0) begin
            state_d = status_i.last ? ST_FIN : ST_IDLE;
          end else begin
            state_d = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_CMP;
      end
      ST_FIN: begin
        if (!ovalid_q || out_ready_i) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.emit) begin
      ovalid_d = 1'b1;
    end else if (out_ready_i) begin
      ovalid_d = 1'b0;
    end else begin
      ovalid_d = ovalid_q;
    end
  end

  assign in_ready_o  = state_q == ST_IDLE;
  assign out_valid_o = ovalid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
    end
  end

endmodule
